// ----- design/cptt_pkg.sv -----
// Package for the periodic CAN transmit table: codes, widths and the row record.
// Used by the interfaces, the row memory and the top level; depends on nothing.
package cptt_pkg;

   localparam int RowCount = 16;
   localparam int RowBits  = (RowCount > 1) ? $clog2(RowCount) : 1;

   localparam logic [31:0] ExtIdMask = 32'h1FFF_FFFF;
   localparam logic [31:0] StdIdMask = 32'h0000_07FF;
   localparam logic [7:0]  BadFlags  = 8'hFC;
   localparam logic [7:0]  BadSelect = 8'hC0;
   localparam logic [7:0]  MaxLength = 8'd8;

   typedef enum logic [2:0] {
      ACT_CREATE   = 3'd0,
      ACT_EDIT     = 3'd1,
      ACT_REMOVE   = 3'd2,
      ACT_TICK     = 3'd3,
      ACT_SNAPSHOT = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_MISSING   = 3'd2,
      ST_BADINDEX  = 3'd3,
      ST_DRVFAIL   = 3'd4,
      ST_NOTFOUND  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_REPLY = 2'd0,
      KIND_FRAME = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_SCAN, S_EMIT
   } state_type;

   typedef struct packed {
      logic        valid;
      logic        enabled;
      logic [1:0]  flags;
      logic [31:0] id;
      logic [3:0]  length;
      logic [63:0] data;
      logic [31:0] period;
      logic [31:0] last_sent;
      logic [31:0] tx_count;
      logic [2:0]  error;
   } row_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  row_index;
      logic [15:0] edit_select;
      logic [7:0]  frame_flags;
      logic [31:0] can_id;
      logic [7:0]  length_code;
      logic [63:0] payload;
      logic [31:0] period_ms;
      logic        enable_bit;
      logic [31:0] now_ms;
      logic        bus_open;
      logic [15:0] send_ok_mask;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  status;
      logic [3:0]  out_index;
      logic [1:0]  out_flags;
      logic [31:0] out_id;
      logic [3:0]  out_length;
      logic [63:0] out_payload;
      logic [31:0] out_period;
      logic        out_enabled;
      logic [31:0] out_tx_count;
      logic [2:0]  out_last_error;
      logic        last_item;
   } rsp_type;

   typedef struct packed {
      logic                 rd_en;
      logic [RowBits-1:0]   rd_addr;
      logic                 wr_en;
      logic [RowBits-1:0]   wr_addr;
   } mem_ctl_type;

endpackage

// ----- design/cptt_if.sv -----
// Valid/ready channel that carries one word of the given payload type.
// Depends on cptt_pkg for the payload types.
interface cptt_req_if (input logic clock);
   cptt_pkg::req_type payload;
   logic valid;
   logic ready;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cptt_rsp_if (input logic clock);
   cptt_pkg::rsp_type payload;
   logic valid;
   logic ready;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/cptt_row_mem.sv -----
// Row store: one synchronous memory of row records, one read and one write port.
// Depends on cptt_pkg; rows not written since reset read as all zero via valid bits.
module cptt_row_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  cptt_pkg::mem_ctl_type ctl,
   input  cptt_pkg::row_type     wr_data,
   output cptt_pkg::row_type     rd_data
);
   import cptt_pkg::*;

   row_type               mem [RowCount];
   logic [RowCount-1:0]   written_ff;
   logic                  hit_ff;
   row_type               q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (ctl.wr_en) begin
         written_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         q_ff   <= mem[ctl.rd_addr];
         hit_ff <= written_ff[ctl.rd_addr];
      end
   end

   assign rd_data = hit_ff ? q_ff : '0;
endmodule

// ----- design/can_periodic_tx_table_top.sv -----
// Periodic CAN transmit table, top level: command decoder and tick scanner.
// Depends on cptt_pkg, cptt_if and cptt_row_mem.
// A command's reply word is registered after the S_READ and S_EXEC states; a new command is taken only in S_IDLE.
// A tick reads each row in S_READ and checks it in S_SCAN, then issues its done word from
// S_EMIT (straight after S_READ with the bus closed); a due row waits while a word is held.
// Synchronous reset empties the table at once and accepts the next word the cycle after.
module can_periodic_tx_table_top (
   input logic       clock,
   input logic       reset,
   cptt_req_if.sink  req,
   cptt_rsp_if.source rsp
);
   import cptt_pkg::*;

   state_type   state_ff, state_in;
   req_type     cmd_ff, cmd_in;
   logic [RowBits:0] row_ff, row_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   mem_ctl_type ctl;
   row_type     rd_row, wr_row;

   cptt_row_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .wr_data (wr_row),
      .rd_data (rd_row)
   );

   logic        idx_ok;
   logic [RowBits-1:0] idx;
   logic [RowBits-1:0] scan_idx;
   logic [63:0] byte_mask;
   logic        due, ok_bit;
   row_type     edit_row;
   rsp_type     reply_w;
   logic        scan_last;

   assign idx_ok   = {24'd0, cmd_ff.row_index} < 32'(RowCount);
   assign idx      = cmd_ff.row_index[RowBits-1:0];
   assign scan_idx = row_ff[RowBits-1:0];
   assign scan_last = row_ff == (RowBits+1)'(RowCount - 1);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[8*i +: 8] = {8{cmd_ff.edit_select[8+i]}};
      end
   end

   assign due = rd_row.valid && rd_row.enabled && (rd_row.period != '0)
                && ((cmd_ff.now_ms - rd_row.last_sent) >= rd_row.period);
   assign ok_bit = ({{(32-RowBits-1){1'b0}}, row_ff} < 32'd16)
                   && cmd_ff.send_ok_mask[row_ff[3:0]];

   // Execute a command against the row read from memory, and update a due row during a tick scan.
   always_comb begin
      edit_row = rd_row;
      reply_w  = '0;
      reply_w.result_kind = KIND_REPLY;
      reply_w.last_item   = 1'b1;
      reply_w.status      = ST_OK;
      wr_row   = rd_row;
      ctl.rd_en   = state_ff == S_READ;
      ctl.rd_addr = (cmd_ff.action == ACT_TICK) ? scan_idx : idx;
      ctl.wr_en   = 1'b0;
      ctl.wr_addr = idx;
      case (cmd_ff.action)
         ACT_CREATE: begin
            if (!idx_ok || (cmd_ff.frame_flags & BadFlags) != '0
                || cmd_ff.length_code > MaxLength) begin
               reply_w.status = ST_INVALID;
            end else begin
               wr_row.valid     = 1'b1;
               wr_row.enabled   = cmd_ff.enable_bit && (cmd_ff.period_ms != '0);
               wr_row.flags     = cmd_ff.frame_flags[1:0];
               wr_row.id        = cmd_ff.can_id;
               wr_row.length    = cmd_ff.length_code[3:0];
               wr_row.data      = cmd_ff.payload;
               wr_row.period    = cmd_ff.period_ms;
               wr_row.last_sent = cmd_ff.now_ms;
               wr_row.tx_count  = '0;
               wr_row.error     = ST_OK;
               ctl.wr_en = state_ff == S_EXEC;
            end
         end
         ACT_EDIT: begin
            if (!idx_ok || (cmd_ff.edit_select[7:0] & BadSelect) != '0) begin
               reply_w.status = ST_INVALID;
            end else if (!rd_row.valid) begin
               reply_w.status = ST_MISSING;
            end else if (cmd_ff.edit_select[2] && cmd_ff.length_code > MaxLength) begin
               reply_w.status = ST_INVALID;
            end else begin
               if (cmd_ff.edit_select[0]) edit_row.flags = cmd_ff.frame_flags[1:0];
               if (cmd_ff.edit_select[1]) edit_row.id = cmd_ff.can_id;
               if (cmd_ff.edit_select[2]) edit_row.length = cmd_ff.length_code[3:0];
               if (cmd_ff.edit_select[3] && cmd_ff.edit_select[15:8] == '0) begin
                  reply_w.status = ST_INVALID;
               end else begin
                  if (cmd_ff.edit_select[3]) begin
                     edit_row.data = (rd_row.data & ~byte_mask)
                                     | (cmd_ff.payload & byte_mask);
                  end
                  if (cmd_ff.edit_select[4]) begin
                     edit_row.period    = cmd_ff.period_ms;
                     edit_row.last_sent = cmd_ff.now_ms;
                  end
                  if (cmd_ff.edit_select[5]) begin
                     edit_row.enabled   = cmd_ff.enable_bit;
                     edit_row.last_sent = cmd_ff.now_ms;
                  end
                  if (edit_row.period == '0) edit_row.enabled = 1'b0;
                  edit_row.error = ST_OK;
               end
               wr_row    = edit_row;
               ctl.wr_en = state_ff == S_EXEC;
            end
         end
         ACT_REMOVE: begin
            if (!idx_ok) begin
               reply_w.status = ST_BADINDEX;
            end else begin
               wr_row    = '0;
               ctl.wr_en = state_ff == S_EXEC;
            end
         end
         ACT_SNAPSHOT: begin
            if (!idx_ok) begin
               reply_w.status = ST_BADINDEX;
            end else if (!rd_row.valid) begin
               reply_w.status = ST_NOTFOUND;
            end else begin
               reply_w.out_index      = 4'(idx);
               reply_w.out_flags      = rd_row.flags;
               reply_w.out_id         = rd_row.id;
               reply_w.out_length     = rd_row.length;
               reply_w.out_payload    = rd_row.data;
               reply_w.out_period     = rd_row.period;
               reply_w.out_enabled    = rd_row.enabled;
               reply_w.out_tx_count   = rd_row.tx_count;
               reply_w.out_last_error = rd_row.error;
            end
         end
         default: begin
            reply_w.status = ST_INVALID;
         end
      endcase
      if (state_ff == S_SCAN) begin
         ctl.wr_addr    = scan_idx;
         wr_row         = rd_row;
         wr_row.last_sent = cmd_ff.now_ms;
         wr_row.tx_count  = ok_bit ? rd_row.tx_count + 32'd1 : rd_row.tx_count;
         wr_row.error     = ok_bit ? ST_OK : ST_DRVFAIL;
         ctl.wr_en        = due && !out_valid_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req.valid && req.ready) state_in = S_READ;
         S_READ: state_in = (cmd_ff.action == ACT_TICK) ?
                            (cmd_ff.bus_open ? S_SCAN : S_EMIT) : S_EXEC;
         S_EXEC: if (!out_valid_ff) state_in = S_IDLE;
         S_SCAN: begin
            if (!due || !out_valid_ff) begin
               state_in = scan_last ? S_EMIT : S_READ;
            end
         end
         S_EMIT: if (!out_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      req.ready    = state_ff == S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.payload;
               row_in = '0;
            end
         end
         S_EXEC: begin
            if (!out_valid_ff) begin
               out_in       = reply_w;
               out_valid_in = 1'b1;
            end
         end
         S_SCAN: begin
            if (due && !out_valid_ff) begin
               out_in = '0;
               out_in.result_kind = KIND_FRAME;
               out_in.status      = ok_bit ? ST_OK : ST_DRVFAIL;
               out_in.out_index   = row_ff[3:0];
               out_in.out_flags   = rd_row.flags;
               out_in.out_id      = rd_row.id & (rd_row.flags[0] ? ExtIdMask : StdIdMask);
               out_in.out_length  = rd_row.length;
               out_in.out_payload = rd_row.data;
               out_valid_in       = 1'b1;
            end
            if (!due || !out_valid_ff) row_in = row_ff + 1'b1;
         end
         S_EMIT: begin
            if (!out_valid_ff) begin
               out_in = '0;
               out_in.result_kind = KIND_DONE;
               out_in.status      = ST_OK;
               out_in.last_item   = 1'b1;
               out_valid_in       = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         row_ff       <= row_in;
      end
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   a_scan_write_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && ctl.wr_en) |-> !out_valid_ff)
      else $error("row written while a frame word is still pending");
   a_idle_after_reply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !out_valid_ff) |=> (state_ff == S_IDLE && out_valid_ff))
      else $error("done marker not issued");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready)
      else $error("word accepted while busy");
endmodule

// ----- test/tb_can_periodic_tx_table_top.sv -----
// Testbench for the periodic CAN transmit table: directed and random commands and ticks,
// each reply word and frame predicted by an independent row model and checked in order.
// Depends on cptt_pkg, cptt_if and the can_periodic_tx_table_top design files.
module tb_can_periodic_tx_table_top;
   import cptt_pkg::*;

   localparam int NumRows = RowCount;

   logic clock;
   logic reset;

   cptt_req_if req (clock);
   cptt_rsp_if rsp (clock);

   can_periodic_tx_table_top dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   typedef struct {
      logic        valid;
      logic        enabled;
      logic [1:0]  flags;
      logic [31:0] id;
      logic [3:0]  length;
      logic [63:0] data;
      logic [31:0] period;
      logic [31:0] last_sent;
      logic [31:0] tx_count;
      logic [2:0]  error;
   } tx_row_type;

   tx_row_type table_rows[NumRows];
   rsp_type    pending_words[$];
   int         mismatch_count;
   int         word_count;
   int         frame_count;
   int         sent_count;
   int         hold_off_cycles;
   bit         random_stall;
   logic [31:0] clock_ms;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Timeout with %0d words still expected.", pending_words.size());
      $display("tb_can_periodic_tx_table_top failed");
      $finish;
   end

   function automatic rsp_type blank_word(kind_type kind, status_type status);
      rsp_type w;
      w = '0;
      w.result_kind = kind;
      w.status = status;
      w.last_item = 1'b1;
      return w;
   endfunction

   function automatic void clear_row(int r);
      table_rows[r] = '{default: '0};
   endfunction

   task automatic predict_words(req_type c);
      int r;
      logic [7:0] sel;
      logic [7:0] dmask;
      logic [63:0] bm;
      rsp_type w;
      r = int'(c.row_index);
      sel = c.edit_select[7:0];
      dmask = c.edit_select[15:8];
      case (c.action)
         ACT_CREATE: begin
            if (r >= NumRows || (c.frame_flags & BadFlags) != 0 || c.length_code > MaxLength) begin
               pending_words.push_back(blank_word(KIND_REPLY, ST_INVALID));
            end else begin
               table_rows[r].valid = 1'b1;
               table_rows[r].enabled = c.enable_bit && c.period_ms != 0;
               table_rows[r].flags = c.frame_flags[1:0];
               table_rows[r].id = c.can_id;
               table_rows[r].length = c.length_code[3:0];
               table_rows[r].data = c.payload;
               table_rows[r].period = c.period_ms;
               table_rows[r].last_sent = c.now_ms;
               table_rows[r].tx_count = '0;
               table_rows[r].error = ST_OK;
               pending_words.push_back(blank_word(KIND_REPLY, ST_OK));
            end
         end
         ACT_EDIT: begin
            if (r >= NumRows || (sel & BadSelect) != 0) begin
               pending_words.push_back(blank_word(KIND_REPLY, ST_INVALID));
            end else if (!table_rows[r].valid) begin
               pending_words.push_back(blank_word(KIND_REPLY, ST_MISSING));
            end else if (sel[2] && c.length_code > MaxLength) begin
               pending_words.push_back(blank_word(KIND_REPLY, ST_INVALID));
            end else begin
               if (sel[0]) table_rows[r].flags = c.frame_flags[1:0];
               if (sel[1]) table_rows[r].id = c.can_id;
               if (sel[2]) table_rows[r].length = c.length_code[3:0];
               if (sel[3] && dmask == 0) begin
                  pending_words.push_back(blank_word(KIND_REPLY, ST_INVALID));
               end else begin
                  if (sel[3]) begin
                     for (int i = 0; i < 8; i++) bm[8*i +: 8] = {8{dmask[i]}};
                     table_rows[r].data = (table_rows[r].data & ~bm) | (c.payload & bm);
                  end
                  if (sel[4]) begin
                     table_rows[r].period = c.period_ms;
                     table_rows[r].last_sent = c.now_ms;
                  end
                  if (sel[5]) begin
                     table_rows[r].enabled = c.enable_bit;
                     table_rows[r].last_sent = c.now_ms;
                  end
                  if (table_rows[r].period == 0) table_rows[r].enabled = 1'b0;
                  table_rows[r].error = ST_OK;
                  pending_words.push_back(blank_word(KIND_REPLY, ST_OK));
               end
            end
         end
         ACT_REMOVE: begin
            if (r >= NumRows) begin
               pending_words.push_back(blank_word(KIND_REPLY, ST_BADINDEX));
            end else begin
               clear_row(r);
               pending_words.push_back(blank_word(KIND_REPLY, ST_OK));
            end
         end
         ACT_TICK: begin
            if (c.bus_open) begin
               for (int k = 0; k < NumRows; k++) begin
                  if (table_rows[k].valid && table_rows[k].enabled && table_rows[k].period != 0
                      && (c.now_ms - table_rows[k].last_sent) >= table_rows[k].period) begin
                     w = '0;
                     w.result_kind = KIND_FRAME;
                     w.status = (k < 16 && c.send_ok_mask[k]) ? ST_OK : ST_DRVFAIL;
                     table_rows[k].last_sent = c.now_ms;
                     if (w.status == ST_OK) table_rows[k].tx_count++;
                     table_rows[k].error = w.status;
                     w.out_index = k[3:0];
                     w.out_flags = table_rows[k].flags;
                     w.out_id = table_rows[k].id &
                        (table_rows[k].flags[0] ? ExtIdMask : StdIdMask);
                     w.out_length = table_rows[k].length;
                     w.out_payload = table_rows[k].data;
                     pending_words.push_back(w);
                  end
               end
            end
            pending_words.push_back(blank_word(KIND_DONE, ST_OK));
         end
         ACT_SNAPSHOT: begin
            if (r >= NumRows) begin
               pending_words.push_back(blank_word(KIND_REPLY, ST_BADINDEX));
            end else if (!table_rows[r].valid) begin
               pending_words.push_back(blank_word(KIND_REPLY, ST_NOTFOUND));
            end else begin
               w = blank_word(KIND_REPLY, ST_OK);
               w.out_index = r[3:0];
               w.out_flags = table_rows[r].flags;
               w.out_id = table_rows[r].id;
               w.out_length = table_rows[r].length;
               w.out_payload = table_rows[r].data;
               w.out_period = table_rows[r].period;
               w.out_enabled = table_rows[r].enabled;
               w.out_tx_count = table_rows[r].tx_count;
               w.out_last_error = table_rows[r].error;
               pending_words.push_back(w);
            end
         end
         default: pending_words.push_back(blank_word(KIND_REPLY, ST_INVALID));
      endcase
   endtask

   // The receiver stalls at random, or for a fixed stretch when one is requested.
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp.ready = 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end else if (random_stall) begin
            gap = $urandom_range(0, 19);
            if (gap > 0) begin
               rsp.ready = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp.ready = 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         word_count++;
         if (pending_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected word %h", rsp.payload);
         end else begin
            want = pending_words.pop_front();
            if (rsp.payload.result_kind == KIND_FRAME) frame_count++;
            if (rsp.payload !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected %h", want);
                  $display("          actual   %h", rsp.payload);
               end
            end
         end
      end
   end

   task automatic send_command(req_type c, bit with_gap = 1'b1);
      int gap;
      gap = with_gap ? $urandom_range(0, 19) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.payload <= c;
      req.valid <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_words(c);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic req_type make_command(logic [2:0] action, logic [7:0] r);
      req_type c;
      c = '0;
      c.action = action;
      c.row_index = r;
      c.now_ms = clock_ms;
      return c;
   endfunction

   function automatic req_type create_command(logic [7:0] r, logic [31:0] period);
      req_type c;
      c = make_command(ACT_CREATE, r);
      c.frame_flags = 8'($urandom_range(0, 3));
      c.can_id = $urandom();
      c.length_code = 8'($urandom_range(0, 8));
      c.payload = {$urandom(), $urandom()};
      c.period_ms = period;
      c.enable_bit = 1'b1;
      return c;
   endfunction

   function automatic req_type tick_command(logic [15:0] ok_mask);
      req_type c;
      c = make_command(ACT_TICK, 8'($urandom()));
      c.bus_open = 1'b1;
      c.send_ok_mask = ok_mask;
      return c;
   endfunction

   task automatic test_directed();
      req_type c;
      c = create_command(0, 1);
      c.frame_flags = 8'h03;
      c.can_id = 32'hFFFF_FFFF;
      c.length_code = 8;
      c.payload = '1;
      send_command(c);
      c = create_command(15, 32'hFFFF_FFFF);
      c.frame_flags = 8'h00;
      c.can_id = 32'hFFFF_FFFF;
      send_command(c);
      c = create_command(16, 5);
      send_command(c);
      c = create_command(3, 5);
      c.frame_flags = 8'hFC;
      send_command(c);
      c = create_command(3, 5);
      c.length_code = 9;
      send_command(c);
      c = create_command(4, 0);
      send_command(c);
      c = make_command(ACT_EDIT, 0);
      c.edit_select = 16'h00C0;
      send_command(c);
      c = make_command(ACT_EDIT, 7);
      c.edit_select = 16'h003F;
      send_command(c);
      c = make_command(ACT_EDIT, 0);
      c.edit_select = 16'h0004;
      c.length_code = 8'hFF;
      send_command(c);
      c = make_command(ACT_EDIT, 0);
      c.edit_select = 16'h000F;
      c.frame_flags = 8'h01;
      c.can_id = 32'h1234_5678;
      c.length_code = 2;
      send_command(c);
      c = make_command(ACT_EDIT, 0);
      c.edit_select = 16'hA538;
      c.payload = 64'h0011_2233_4455_6677;
      c.period_ms = 2;
      c.enable_bit = 1'b1;
      send_command(c);
      c = make_command(ACT_EDIT, 15);
      c.edit_select = 16'h0010;
      send_command(c);
      clock_ms = clock_ms + 3;
      send_command(tick_command(16'h0000));
      clock_ms = clock_ms + 3;
      send_command(tick_command(16'hFFFF));
      c = tick_command(16'hFFFF);
      c.bus_open = 1'b0;
      send_command(c);
      send_command(make_command(ACT_SNAPSHOT, 0));
      send_command(make_command(ACT_SNAPSHOT, 9));
      send_command(make_command(ACT_SNAPSHOT, 255));
      send_command(make_command(ACT_REMOVE, 200));
      send_command(make_command(ACT_REMOVE, 0));
      send_command(make_command(ACT_SNAPSHOT, 0));
      for (int a = 5; a < 8; a++) send_command(make_command(a[2:0], 1));
   endtask

   // Fill the table, stop the receiver and keep sending ticks that each produce many frames.
   task automatic test_back_pressure();
      wait_drained();
      for (int r = 0; r < NumRows; r++) send_command(create_command(8'(r), 1), 1'b0);
      hold_off_cycles = 400;
      for (int k = 0; k < 4; k++) begin
         clock_ms = clock_ms + 2;
         send_command(tick_command(16'($urandom())), 1'b0);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      req_type c;
      int pick;
      for (int n = 0; n < 40; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            c = create_command(8'($urandom_range(0, NumRows - 1)), $urandom_range(0, 12));
            c.enable_bit = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) == 0) c.frame_flags = 8'($urandom());
            if ($urandom_range(0, 9) == 0) c.length_code = 8'($urandom());
            if ($urandom_range(0, 9) == 0) c.period_ms = $urandom();
            if ($urandom_range(0, 19) == 0) c.row_index = 8'($urandom());
         end else if (pick < 40) begin
            c = make_command(ACT_EDIT, 8'($urandom_range(0, NumRows - 1)));
            c.edit_select = {8'($urandom_range(0, 255)), 2'b00, 6'($urandom())};
            if ($urandom_range(0, 9) == 0) c.edit_select = 16'($urandom());
            if ($urandom_range(0, 19) == 0) c.row_index = 8'($urandom());
            c.frame_flags = 8'($urandom_range(0, 3));
            c.can_id = $urandom();
            c.length_code = ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                                         : 8'($urandom_range(0, 8));
            c.payload = {$urandom(), $urandom()};
            c.period_ms = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 12);
            c.enable_bit = 1'($urandom());
         end else if (pick < 47) begin
            c = make_command(ACT_REMOVE, 8'(($urandom_range(0, 9) == 0) ?
                             $urandom() : $urandom_range(0, NumRows - 1)));
         end else if (pick < 85) begin
            clock_ms = clock_ms + $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0) clock_ms = clock_ms + 32'hFFFF_FFF0;
            c = tick_command(16'($urandom()));
            c.bus_open = $urandom_range(0, 7) != 0;
         end else if (pick < 97) begin
            c = make_command(ACT_SNAPSHOT, 8'(($urandom_range(0, 9) == 0) ?
                             $urandom() : $urandom_range(0, NumRows - 1)));
         end else begin
            c = make_command(3'($urandom_range(5, 7)), 8'($urandom()));
         end
         send_command(c);
      end
   endtask

   task automatic test_paused_sender();
      wait_drained();
      clock_ms = clock_ms + 20;
      send_command(tick_command(16'hFFFF));
      for (int r = 0; r < NumRows; r++) send_command(make_command(ACT_SNAPSHOT, 8'(r)));
   endtask

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      reset = 1'b1;
      mismatch_count = 0;
      word_count = 0;
      frame_count = 0;
      sent_count = 0;
      hold_off_cycles = 0;
      random_stall = 1'b0;
      clock_ms = 32'hFFFF_FFF8;
      for (int r = 0; r < NumRows; r++) clear_row(r);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      random_stall = 1'b1;
      test_back_pressure();
      test_random_traffic();
      test_paused_sender();
      wait_drained();
      $display("Covered %0d commands and %0d result words, %0d of them frames,",
               sent_count, word_count, frame_count);
      $display("with random stalls, a long receiver hold-off and a drained pause.");
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("tb_can_periodic_tx_table_top passed");
      end else begin
         $display("%0d mismatches, %0d words missing.", mismatch_count, pending_words.size());
         $display("tb_can_periodic_tx_table_top failed");
      end
      $finish;
   end

endmodule
